// ----- rtl/atdc_pkg.sv -----
`default_nettype none

package atdc_pkg;

	// Configuration data width (widest register)
	localparam int unsigned CFG_W = 31;
	localparam int unsigned PERIOD_W = 17;

	// Lower bound of the inertia band, 0.001 in Q16.16
	localparam logic [31:0] DB_FLOOR = 32'd66;

	// Register reset values
	localparam logic [30:0] RST_GAIN_LAMBDA  = 31'd655360;
	localparam logic [30:0] RST_GAIN_ALPHA   = 31'd65536;
	localparam logic [30:0] RST_GAIN_OMEGA   = 31'd0;
	localparam logic [30:0] RST_MASS_INITIAL = 31'd6554;
	localparam logic [30:0] RST_MASS_CEILING = 31'd655360;
	localparam logic [16:0] RST_TICK_PERIOD  = 17'd66;
	localparam logic [30:0] RST_TICK_RATE    = 31'd65536000;

	// Register indexes
	typedef enum logic [2:0] {
		REG_GAIN_LAMBDA  = 3'd0,
		REG_GAIN_ALPHA   = 3'd1,
		REG_GAIN_OMEGA   = 3'd2,
		REG_MASS_INITIAL = 3'd3,
		REG_MASS_CEILING = 3'd4,
		REG_TICK_PERIOD  = 3'd5,
		REG_TICK_RATE    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [30:0] gain_lambda;
		logic [30:0] gain_alpha;
		logic [30:0] gain_omega;
		logic [30:0] mass_ceiling;
		logic [16:0] tick_period;
		logic [30:0] tick_rate;
	} cfg_regs_t;

	typedef struct packed {
		logic signed [31:0] pos_measured;
		logic signed [31:0] vel_measured;
		logic signed [31:0] pos_target;
		logic signed [31:0] vel_target;
		logic signed [31:0] acc_target;
	} in_t;

	typedef struct packed {
		logic signed [31:0] torque_out;
		logic signed [31:0] mass_estimate;
	} out_t;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	// Sequencer steps, one per cycle; the last step holds while an earlier result is still stalled
	typedef enum logic [3:0] {
		ST_LE     = 4'd0,
		ST_LL     = 4'd1,
		ST_ACC    = 4'd2,
		ST_AO     = 4'd3,
		ST_AS     = 4'd4,
		ST_LLED   = 4'd5,
		ST_AS2    = 4'd6,
		ST_AOE    = 4'd7,
		ST_RATE   = 4'd8,
		ST_PR     = 4'd9,
		ST_EST    = 4'd10,
		ST_EA     = 4'd11,
		ST_EDED   = 4'd12,
		ST_TORQUE = 4'd13
	} step_t;

endpackage

`default_nettype wire

// ----- rtl/atdc_mul.sv -----
`default_nettype none

module atdc_mul
	import atdc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [31:0] p_q
);

	logic signed [63:0] prod;

	// Full signed product; floor shift by 16 keeps bits 47:16
	assign prod = $signed(a) * $signed(b);

	// Capture product only on multiply steps
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= prod[47:16];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/atdc_cfg.sv -----
`default_nettype none

module atdc_cfg
	import atdc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output cfg_regs_t             regs
);

	cfg_regs_t regs_q;

	assign regs = regs_q;

	// Register file; writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.gain_lambda  <= RST_GAIN_LAMBDA;
			regs_q.gain_alpha   <= RST_GAIN_ALPHA;
			regs_q.gain_omega   <= RST_GAIN_OMEGA;
			regs_q.mass_ceiling <= RST_MASS_CEILING;
			regs_q.tick_period  <= RST_TICK_PERIOD;
			regs_q.tick_rate    <= RST_TICK_RATE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_LAMBDA:  regs_q.gain_lambda  <= cfg_data;
				REG_GAIN_ALPHA:   regs_q.gain_alpha   <= cfg_data;
				REG_GAIN_OMEGA:   regs_q.gain_omega   <= cfg_data;
				REG_MASS_CEILING: regs_q.mass_ceiling <= cfg_data;
				REG_TICK_PERIOD:  regs_q.tick_period  <= cfg_data[PERIOD_W-1:0];
				REG_TICK_RATE:    regs_q.tick_rate    <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/adaptive_tdc_joint_torque.sv -----
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    in_data   (in_t)
// out       output     out_valid/out_stall  out_data  (out_t)
// cfg       input      cfg_we               cfg_index, cfg_data
//
// An item is taken in a transfer cycle and then runs 14 sequencer steps, eleven of
// them on the single shared 32x32 multiplier. in_stall is high while an item runs.
// The result sits in an output register; the last step holds while an earlier
// result is still stalled. Reset loads the inertia estimate from mass_initial and
// clears rate, last torque and last velocity.

module adaptive_tdc_joint_torque
	import atdc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_t              in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_t                  out_data
);

	cfg_regs_t regs;
	state_t    state_q, state_d;
	step_t     step_q;

	logic in_xfer, finish;

	// Tick state
	logic [31:0] est_q, rate_q, torque_prev_q, vel_prev_q;
	// Per-item operands and intermediates
	logic [31:0] e_q, ed_q, dv_q, acc_t_q, vel_m_q;
	logic [31:0] le_q, ll_q, s_q, acc_q, ao_q, as_q, lled_q, ded_q;

	// Multiplier
	logic        mul_en;
	logic [31:0] mul_a, mul_b, p_q;

	// Clamp and band logic
	logic        in_band;
	logic [31:0] est_lo, est_clamped;
	logic [31:0] ceil_ext;

	logic        out_valid_q;
	out_t        out_q;

	atdc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	atdc_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake
	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != S_IDLE);
		finish   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				if (step_q == ST_TORQUE && (!out_valid_q || !out_stall)) begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Select multiplier operands per step
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		if (state_q == S_RUN) begin
			case (step_q)
				ST_LE: begin
					mul_en = 1'b1;
					mul_a  = {1'b0, regs.gain_lambda};
					mul_b  = e_q;
				end
				ST_LL: begin
					mul_en = 1'b1;
					mul_a  = {1'b0, regs.gain_lambda};
					mul_b  = {1'b0, regs.gain_lambda};
				end
				ST_ACC: begin
					mul_en = 1'b1;
					mul_a  = dv_q;
					mul_b  = {1'b0, regs.tick_rate};
				end
				ST_AO: begin
					mul_en = 1'b1;
					mul_a  = {1'b0, regs.gain_alpha};
					mul_b  = {1'b0, regs.gain_omega};
				end
				ST_AS: begin
					mul_en = 1'b1;
					mul_a  = {1'b0, regs.gain_alpha};
					mul_b  = s_q;
				end
				ST_LLED: begin
					mul_en = 1'b1;
					mul_a  = ll_q;
					mul_b  = ed_q;
				end
				ST_AS2: begin
					mul_en = 1'b1;
					mul_a  = as_q;
					mul_b  = s_q;
				end
				ST_AOE: begin
					mul_en = 1'b1;
					mul_a  = ao_q;
					mul_b  = est_q;
				end
				ST_PR: begin
					mul_en = 1'b1;
					mul_a  = {{(32-PERIOD_W){1'b0}}, regs.tick_period};
					mul_b  = rate_q;
				end
				ST_EA: begin
					mul_en = 1'b1;
					mul_a  = est_q;
					mul_b  = acc_q;
				end
				ST_EDED: begin
					mul_en = 1'b1;
					mul_a  = est_q;
					mul_b  = ded_q;
				end
				default: ;
			endcase
		end
	end

	// Band test on the estimate at tick start, then floor and ceiling clamps
	assign ceil_ext    = {1'b0, regs.mass_ceiling};
	assign in_band     = ($signed(est_q) > $signed(DB_FLOOR))
	                  && ($signed(est_q) < $signed(ceil_ext));
	assign est_lo      = ($signed(est_q) < $signed(DB_FLOOR)) ? DB_FLOOR : est_q;
	assign est_clamped = ($signed(est_lo) > $signed(ceil_ext)) ? (ceil_ext - DB_FLOOR)
	                                                           : est_lo;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_LE;
		end else if (in_xfer) begin
			step_q <= ST_LE;
		end else if (state_q == S_RUN && step_q != ST_TORQUE) begin
			step_q <= step_t'(step_q + 4'd1);
		end
	end

	// Tick state: estimate, rate, last torque, last velocity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q         <= {1'b0, RST_MASS_INITIAL};
			rate_q        <= '0;
			torque_prev_q <= '0;
			vel_prev_q    <= '0;
		end else if (cfg_we && cfg_index == REG_MASS_INITIAL) begin
			est_q <= {1'b0, cfg_data};
		end else if (state_q == S_RUN) begin
			case (step_q)
				ST_RATE: begin
					if (in_band) begin
						rate_q <= as_q - p_q;
					end
					est_q <= est_clamped;
				end
				ST_EST: est_q <= est_q + p_q;
				ST_TORQUE: begin
					if (finish) begin
						torque_prev_q <= p_q + torque_prev_q - acc_q;
						vel_prev_q    <= vel_m_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Capture item operands on transfer and write back products
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			e_q     <= in_data.pos_target - in_data.pos_measured;
			ed_q    <= in_data.vel_target - in_data.vel_measured;
			dv_q    <= in_data.vel_measured - vel_prev_q;
			acc_t_q <= in_data.acc_target;
			vel_m_q <= in_data.vel_measured;
		end else if (state_q == S_RUN) begin
			case (step_q)
				ST_LL:   le_q   <= p_q;
				ST_ACC: begin
					ll_q <= p_q;
					s_q  <= ed_q + le_q;
				end
				ST_AO:   acc_q  <= p_q;
				ST_AS:   ao_q   <= p_q;
				ST_LLED: as_q   <= p_q;
				ST_AS2:  lled_q <= p_q;
				// second product alpha*s*s replaces alpha*s
				ST_AOE:  as_q   <= p_q;
				ST_RATE: ded_q  <= acc_t_q + {le_q[30:0], 1'b0} + lled_q;
				// est*acc replaces acc for the torque sum
				ST_EDED: acc_q  <= p_q;
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.torque_out    <= p_q + torque_prev_q - acc_q;
			out_q.mass_estimate <= est_q;
		end
	end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import atdc_pkg::*;

	// Index with no register behind it; writes to it must be dropped
	localparam logic [2:0]  REG_SPARE      = 3'd7;
	// Lower edge of the inertia band, 0.001 in Q16.16
	localparam logic [31:0] MASS_FLOOR     = 32'd66;
	// Cycles without any transfer before the run is declared hung
	localparam int          WATCHDOG_LIMIT = 5000;
	localparam int          RANDOM_PHASES  = 13;
	localparam int          PHASE_ITEMS    = 100;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [2:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_t             out_data;

	// Mirror of the controller: configuration and per-joint state
	logic [30:0] lam_q, alpha_q, omega_q, mass_init_q, ceil_q, rate_q;
	logic [16:0] period_q;
	logic [31:0] est_q, est_rate_q, torque_prev_q, vel_prev_q;

	// Torque/estimate pairs still owed by the block, oldest first
	out_t pending_torques[$];
	int   mismatches = 0;
	int   stall_left = 0;
	int   quiet_cycles = 0;
	bit   pace_on = 1'b1;

	adaptive_tdc_joint_torque u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial forever #2 clk = ~clk;

	// Q16.16 product: full signed product, floor shift, keep low word
	function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
		logic signed [63:0] p;
		p = $signed(a) * $signed(b);
		return p[47:16];
	endfunction

	function automatic void load_reset_state();
		lam_q         = 31'd655360;
		alpha_q       = 31'd65536;
		omega_q       = 31'd0;
		mass_init_q   = 31'd6554;
		ceil_q        = 31'd655360;
		period_q      = 17'd66;
		rate_q        = 31'd65536000;
		est_q         = {1'b0, mass_init_q};
		est_rate_q    = '0;
		torque_prev_q = '0;
		vel_prev_q    = '0;
	endfunction

	// Append one expected result at the tail of the owed list
	function automatic void owe_result(input out_t res);
		pending_torques = {pending_torques, res};
	endfunction

	// Advance the mirrored controller by one tick and return its result
	function automatic out_t predict_torque(input in_t item);
		logic [31:0] acc, e, ed, le, s, est, ceiling, ded, tde, torque;
		out_t res;
		acc = qmul(item.vel_measured - vel_prev_q, {1'b0, rate_q});
		e = item.pos_target - item.pos_measured;
		ed = item.vel_target - item.vel_measured;
		le = qmul({1'b0, lam_q}, e);
		s = ed + le;
		est = est_q;
		ceiling = {1'b0, ceil_q};
		// adapt only strictly inside the band, else hold the last rate
		if ($signed(MASS_FLOOR) < $signed(est) && $signed(est) < $signed(ceiling))
			est_rate_q = qmul(qmul({1'b0, alpha_q}, s), s)
				- qmul(qmul({1'b0, alpha_q}, {1'b0, omega_q}), est);
		if ($signed(est) < $signed(MASS_FLOOR))
			est = MASS_FLOOR;
		if ($signed(est) > $signed(ceiling))
			est = ceiling - MASS_FLOOR;
		est = est + qmul({15'd0, period_q}, est_rate_q);
		ded = item.acc_target + {le[30:0], 1'b0}
			+ qmul(qmul({1'b0, lam_q}, {1'b0, lam_q}), ed);
		tde = torque_prev_q - qmul(est, acc);
		torque = qmul(est, ded) + tde;
		torque_prev_q = torque;
		vel_prev_q = item.vel_measured;
		est_q = est;
		res.torque_out = torque;
		res.mass_estimate = est;
		return res;
	endfunction

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!pace_on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic in_t make_item(input logic [31:0] pm, input logic [31:0] vm,
			input logic [31:0] pt, input logic [31:0] vt, input logic [31:0] at);
		in_t item;
		item = '{pm, vm, pt, vt, at};
		return item;
	endfunction

	// Joint-like values near zero most of the time, raw words otherwise
	function automatic logic [31:0] rand_word(input bit tame);
		if (tame)
			return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] pick_reg(input logic [30:0] lo, input logic [30:0] hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return 31'($urandom_range(lo, hi));
		endcase
	endfunction

	// Output side back-pressure
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (pace_on && $urandom_range(0, 3) == 0) begin
			stall_left <= pick_gap();
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare every output transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_torques.size() == 0) begin
				$display("%0t: unexpected result torque %h mass %h", $time,
					out_data.torque_out, out_data.mass_estimate);
				mismatches++;
			end else begin
				want = pending_torques.pop_front();
				if (out_data.torque_out !== want.torque_out) begin
					$display("%0t: torque_out expected %h actual %h", $time,
						want.torque_out, out_data.torque_out);
					mismatches++;
				end
				if (out_data.mass_estimate !== want.mass_estimate) begin
					$display("%0t: mass_estimate expected %h actual %h", $time,
						want.mass_estimate, out_data.mass_estimate);
					mismatches++;
				end
			end
		end
	end

	// Count cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Present one item, hold it until the transfer, then record its result
	task automatic send_item(input in_t item);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		owe_result(predict_torque(item));
	endtask

	// Drop valid and wait until every owed result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_torques.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [30:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_GAIN_LAMBDA:  lam_q = value;
			REG_GAIN_ALPHA:   alpha_q = value;
			REG_GAIN_OMEGA:   omega_q = value;
			REG_MASS_INITIAL: begin
				mass_init_q = value;
				est_q = {1'b0, value};
			end
			REG_MASS_CEILING: ceil_q = value;
			REG_TICK_PERIOD:  period_q = value[16:0];
			REG_TICK_RATE:    rate_q = value;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [30:0] lam, input logic [30:0] alpha,
			input logic [30:0] omega, input logic [30:0] mass_init,
			input logic [30:0] ceiling, input logic [30:0] period, input logic [30:0] rate);
		write_reg(REG_GAIN_LAMBDA, lam);
		write_reg(REG_GAIN_ALPHA, alpha);
		write_reg(REG_GAIN_OMEGA, omega);
		write_reg(REG_MASS_CEILING, ceiling);
		write_reg(REG_TICK_PERIOD, period);
		write_reg(REG_TICK_RATE, rate);
		write_reg(REG_MASS_INITIAL, mass_init);
	endtask

	// A few ordinary ticks on the power-up configuration
	task automatic test_reset_defaults();
		send_item(make_item(32'h0001_0000, 32'h0000_8000, 32'h0001_8000, 32'h0001_0000, 32'h0));
		send_item(make_item(32'h0001_1000, 32'h0000_9000, 32'h0001_8000, 32'h0001_0000,
			32'h0002_0000));
		send_item(make_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
		drain();
	endtask

	// Extreme words and alternating patterns on every input field
	task automatic test_field_extremes();
		send_item(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF));
		send_item(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000));
		send_item(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		send_item(make_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA));
		send_item(make_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555));
		send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
		drain();
	endtask

	// Estimate below, on and above the band edges, held rate, inverted band
	task automatic test_band_edges();
		write_reg(REG_MASS_INITIAL, 31'd131072);
		send_item(make_item(32'h0, 32'h0, 32'h0002_0000, 32'h0001_0000, 32'h0));
		drain();
		// above the ceiling: clamp, and integrate the held rate
		write_reg(REG_MASS_INITIAL, 31'd1310720);
		send_item(make_item(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0));
		drain();
		write_reg(REG_MASS_INITIAL, 31'd0);
		send_item(make_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
		drain();
		write_reg(REG_MASS_INITIAL, MASS_FLOOR[30:0]);
		send_item(make_item(32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0));
		drain();
		write_reg(REG_MASS_INITIAL, 31'd655360);
		send_item(make_item(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0));
		drain();
		// ceiling under the floor: both clamps fire in turn
		write_reg(REG_MASS_CEILING, 31'd1);
		write_reg(REG_MASS_INITIAL, 31'd40);
		send_item(make_item(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0));
		send_item(make_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
		drain();
	endtask

	// Register extremes, dropped upper bits and the unused index
	task automatic test_register_edges();
		write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		send_item(make_item(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0, 32'hFFFF_0000));
		send_item(make_item(32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h0));
		drain();
		write_all(31'd0, 31'd0, 31'd0, 31'd0, 31'd1, 31'd1, 31'd1);
		send_item(make_item(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0, 32'h0001_0000));
		send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0));
		drain();
		write_all(31'd655360, 31'd65536, 31'd32768, 31'd131072, 31'd655360, 31'd65536,
			31'd65536);
		write_reg(REG_SPARE, 31'h7FFF_FFFF);
		send_item(make_item(32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0001_0000, 32'h0));
		send_item(make_item(32'h0001_4000, 32'h0000_4000, 32'h0002_0000, 32'h0001_0000,
			32'h0000_8000));
		drain();
	endtask

	// Phases of random configuration, each followed by random ticks
	task automatic test_random_traffic();
		bit tame;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			pace_on = (phase % 4) != 3;
			if (phase % 3 == 2)
				write_all(pick_reg(31'd0, 31'h7FFF_FFFF), pick_reg(31'd0, 31'h7FFF_FFFF),
					pick_reg(31'd0, 31'h7FFF_FFFF), pick_reg(31'd0, 31'h7FFF_FFFF),
					pick_reg(31'd1, 31'h7FFF_FFFF), pick_reg(31'd1, 31'd65536),
					pick_reg(31'd1, 31'h7FFF_FFFF));
			else
				write_all(31'($urandom_range(0, 2621440)), 31'($urandom_range(0, 262144)),
					31'($urandom_range(0, 131072)), 31'($urandom_range(0, 1310720)),
					31'($urandom_range(1, 1310720)), 31'($urandom_range(1, 655)),
					31'($urandom_range(1, 131072000)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				tame = $urandom_range(0, 3) != 0;
				send_item(make_item(rand_word(tame), rand_word(tame), rand_word(tame),
					rand_word(tame), rand_word(tame)));
			end
			drain();
		end
		pace_on = 1'b1;
	endtask

	initial begin
		load_reset_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_band_edges();
		test_register_edges();
		test_random_traffic();
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_torques.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/atdc_pkg.sv
rtl/atdc_mul.sv
rtl/atdc_cfg.sv
rtl/adaptive_tdc_joint_torque.sv
tb/sv/tb_top.sv
